@@ rtl/kch_pkg.sv @@
package kch_pkg;

  // default build sizes
  localparam int MAX_K_DEF      = 10;
  localparam int COUNT_BITS_DEF = 32;

  // fixed field widths
  localparam int KLEN_W  = 4;
  localparam int RUN_W   = 4;
  localparam int CHAR_W  = 8;
  localparam int INDEX_W = 20;
  localparam int ECNT_W  = 32;
  localparam int TOTAL_W = 48;

  localparam logic [KLEN_W-1:0]  KLEN_RESET = 4'd6;
  localparam logic [KLEN_W-1:0]  KLEN_MIN   = 4'd2;
  localparam logic [TOTAL_W-1:0] TOTAL_MAX  = '1;

  // operation codes
  localparam logic OP_PUSH = 1'b0;
  localparam logic OP_READ = 1'b1;

  // base codes, with one code for anything that is not a base
  localparam logic [2:0] CODE_A        = 3'd0;
  localparam logic [2:0] CODE_C        = 3'd1;
  localparam logic [2:0] CODE_G        = 3'd2;
  localparam logic [2:0] CODE_T        = 3'd3;
  localparam logic [2:0] CODE_NOT_BASE = 3'd4;

  function automatic logic [2:0] base_code(input logic [CHAR_W-1:0] c);
    logic [2:0] code;
    case (c)
      8'h41, 8'h61: code = CODE_A;
      8'h43, 8'h63: code = CODE_C;
      8'h47, 8'h67: code = CODE_G;
      8'h54, 8'h74, 8'h55, 8'h75: code = CODE_T;
      default: code = CODE_NOT_BASE;
    endcase
    return code;
  endfunction

endpackage

@@ rtl/kmer_count_histogram_core.sv @@
// k-mer count histogram core
//
// Input channel (in_valid / in_stall): one beat per character or table read.
// op = push: base_char goes into the rolling 2-bit-per-base window; read_start
// marks the first character of a read. Each full window of kmer_length bases
// bumps its table entry and the total k-mer count, both saturating.
// op = read: entry_index selects a table entry whose count is returned.
// Output channel (out_valid / out_stall): exactly one result beat per input
// beat, in order.
// Each beat passes the stage 1 and output registers; throughput is one beat
// per cycle while out_stall is low, with a forwarding register covering
// back-to-back updates of the same entry in the registered-read count memory.
// A stalled output holds its beat; the input keeps being taken until the
// middle stage is also full, then in_stall rises.
// Reset (rst, synchronous) clears window, run length, total and kmer_length
// (back to 6), then sweeps all 4**MAX_K entries of the count memory to zero
// one entry per cycle, with in_stall high throughout. cfg_write / cfg_data set
// kmer_length at any time and should be used only while the block is idle.
module kmer_count_histogram_core #(
  parameter int MAX_K      = kch_pkg::MAX_K_DEF,
  parameter int COUNT_BITS = kch_pkg::COUNT_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_write,
  input  logic [kch_pkg::KLEN_W-1:0]   cfg_data,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic                         op,
  input  logic [kch_pkg::CHAR_W-1:0]   base_char,
  input  logic                         read_start,
  input  logic [kch_pkg::INDEX_W-1:0]  entry_index,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [kch_pkg::INDEX_W-1:0]  kmer_index,
  output logic                         kmer_counted,
  output logic [kch_pkg::ECNT_W-1:0]   entry_count,
  output logic [kch_pkg::TOTAL_W-1:0]  total_kmers
);
  import kch_pkg::*;

  localparam int ADDR_W = 2 * MAX_K;
  localparam int DEPTH  = 1 << ADDR_W;

  // configuration
  logic [KLEN_W-1:0] kmer_length;

  always_ff @(posedge clk) begin
    if (rst) begin
      kmer_length <= KLEN_RESET;
    end else if (cfg_write) begin
      kmer_length <= cfg_data;
    end
  end

  // clearing sweep after reset
  logic              clearing;
  logic [ADDR_W-1:0] clr_addr;

  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_addr <= '0;
    end else if (clearing) begin
      clr_addr <= clr_addr + 1'b1;
      if (&clr_addr) begin
        clearing <= 1'b0;
      end
    end
  end

  // pipeline handshake
  logic s1_valid;
  logic s1_load;
  logic s1_advance;
  logic accept;

  assign s1_advance = !out_valid || !out_stall;
  assign s1_load    = !s1_valid || s1_advance;
  assign in_stall   = clearing || !s1_load;
  assign accept     = in_valid && !in_stall;

  // window and run length, updated as each push beat is taken
  logic [ADDR_W-1:0] window_bits, window_next;
  logic [RUN_W-1:0]  valid_run, valid_run_next;
  logic [KLEN_W-1:0] k_eff;
  logic [ADDR_W-1:0] kmask;
  logic [2:0]        code;
  logic [RUN_W-1:0]  run_base;
  logic [ADDR_W-1:0] push_idx;
  logic              push_counted;
  logic [ADDR_W-1:0] read_idx;
  logic [ADDR_W+INDEX_W-1:0] entry_ext;

  always_comb begin
    if (kmer_length < KLEN_MIN) begin
      k_eff = KLEN_MIN;
    end else if (kmer_length > KLEN_W'(MAX_K)) begin
      k_eff = KLEN_W'(MAX_K);
    end else begin
      k_eff = kmer_length;
    end
    for (int i = 0; i < ADDR_W; i++) begin
      kmask[i] = (5'(i) < {k_eff, 1'b0});
    end
  end

  always_comb begin
    code           = base_code(base_char);
    run_base       = read_start ? '0 : valid_run;
    window_next    = window_bits;
    valid_run_next = valid_run;
    push_idx       = '0;
    push_counted   = 1'b0;
    if (code == CODE_NOT_BASE) begin
      window_next    = '0;
      valid_run_next = '0;
    end else begin
      window_next    = {window_bits[ADDR_W-3:0], code[1:0]};
      valid_run_next = (run_base < RUN_W'(MAX_K)) ? run_base + 1'b1 : run_base;
      push_idx       = window_next & kmask;
      push_counted   = (valid_run_next >= RUN_W'(k_eff));
    end
  end

  assign entry_ext = {{ADDR_W{1'b0}}, entry_index};
  assign read_idx  = entry_ext[ADDR_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      window_bits <= '0;
      valid_run   <= '0;
    end else if (accept && op == OP_PUSH) begin
      window_bits <= window_next;
      valid_run   <= valid_run_next;
    end
  end

  // stage 1 registers: item waiting for its count read
  logic              s1_op;
  logic              s1_counted;
  logic [ADDR_W-1:0] s1_addr;
  logic [ADDR_W-1:0] rd_addr;

  assign rd_addr = (op == OP_READ) ? read_idx : push_idx;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s1_load) begin
      s1_valid <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_op      <= op;
      s1_counted <= (op == OP_PUSH) && push_counted;
      s1_addr    <= rd_addr;
    end
  end

  // count memory
  logic [COUNT_BITS-1:0] count_store [DEPTH];
  logic [COUNT_BITS-1:0] mem_rdata;
  logic                  mem_we;
  logic [ADDR_W-1:0]     mem_waddr;
  logic [COUNT_BITS-1:0] mem_wdata;
  logic                  upd_we;
  logic [COUNT_BITS-1:0] upd_count;

  assign upd_we    = s1_valid && s1_advance && s1_counted;
  assign mem_we    = clearing || upd_we;
  assign mem_waddr = clearing ? clr_addr : s1_addr;
  assign mem_wdata = clearing ? '0 : upd_count;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      count_store[mem_waddr] <= mem_wdata;
    end
    if (accept) begin
      mem_rdata <= count_store[rd_addr];
    end
  end

  // last write, forwarded to a read that raced it
  logic                  fwd_valid;
  logic [ADDR_W-1:0]     fwd_addr;
  logic [COUNT_BITS-1:0] fwd_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      fwd_valid <= 1'b0;
    end else if (clearing) begin
      fwd_valid <= 1'b0;
    end else if (upd_we) begin
      fwd_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (upd_we) begin
      fwd_addr <= s1_addr;
      fwd_data <= upd_count;
    end
  end

  // read-modify-write of the entry and the total
  logic [COUNT_BITS-1:0] cur_count;
  logic [COUNT_BITS-1:0] res_count;
  logic [TOTAL_W-1:0]    kmer_total, total_next;

  always_comb begin
    cur_count = (fwd_valid && fwd_addr == s1_addr) ? fwd_data : mem_rdata;
    upd_count = (&cur_count) ? cur_count : cur_count + 1'b1;
    if (s1_counted) begin
      res_count = upd_count;
    end else if (s1_op == OP_READ) begin
      res_count = cur_count;
    end else begin
      res_count = '0;
    end
    total_next = (s1_counted && kmer_total != TOTAL_MAX) ? kmer_total + 1'b1 : kmer_total;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      kmer_total <= '0;
    end else if (s1_valid && s1_advance) begin
      kmer_total <= total_next;
    end
  end

  // output register
  logic [COUNT_BITS+ECNT_W-1:0] cnt_ext;
  logic [ADDR_W+INDEX_W-1:0]    idx_ext;

  assign cnt_ext = {{ECNT_W{1'b0}}, res_count};
  assign idx_ext = {{INDEX_W{1'b0}}, s1_addr};

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_advance) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_valid && s1_advance) begin
      kmer_index   <= idx_ext[INDEX_W-1:0];
      kmer_counted <= s1_counted;
      entry_count  <= cnt_ext[ECNT_W-1:0];
      total_kmers  <= total_next;
    end
  end

endmodule
